// ===== rtl/integer_to_radix_text_core_assert.svh =====
// ----------------------------------------------------------------------------
// integer_to_radix_text_core assertion macros
// Concurrent check macros for the radix text core; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_TEXT_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_TEXT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ITRT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ITRT_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ITRT_ASSERT_IMP(name, clk, rst, ante, cons)
`define ITRT_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/itrt_pkg.sv =====
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared widths, register indexes and character helpers for the radix text core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package itrt_pkg;

  localparam int VALUE_W        = 32;  // input word field
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 7;
  localparam int LEN_W          = 6;
  localparam int OUT_DATA_W     = 16;  // char + length, padded to bytes
  localparam int STORE_DEPTH    = 32;
  localparam int STORE_AW       = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int DIV_STEP_BITS  = 8;   // quotient bits resolved per divider cycle

  localparam logic [CFG_IDX_W-1:0] REG_RADIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'd1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else if (upper) begin
      res = CHAR_UPPER + CHAR_W'(d - 4'd10);
    end else begin
      res = CHAR_LOWER + CHAR_W'(d - 4'd10);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/itrt_ram.sv =====
// ----------------------------------------------------------------------------
// itrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module itrt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/itrt_div.sv =====
// ----------------------------------------------------------------------------
// itrt_div
// Iterative divider by a small radix: DIV_STEP_BITS restoring steps per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module itrt_div
  import itrt_pkg::*;
#(
  parameter int MAG_W = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MAG_W-1:0]   dividend,
  input  wire logic [RADIX_W-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic      [MAG_W-1:0]   quotient,
  output logic      [DIGIT_W-1:0] remainder
);

  localparam int STEPS = MAG_W / DIV_STEP_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [MAG_W-1:0]   work;
  logic [DIGIT_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic [MAG_W-1:0]   work_next;
  logic [DIGIT_W-1:0] rem_next;

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    logic [RADIX_W-1:0] partial;
    logic               qbit;
    work_next = work;
    rem_next  = rem;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      partial   = {rem_next, work_next[MAG_W-1]};
      qbit      = (partial >= divisor);
      rem_next  = qbit ? DIGIT_W'(partial - divisor) : partial[DIGIT_W-1:0];
      work_next = {work_next[MAG_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        busy <= (cnt != CNT_W'(1));
        cnt  <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign remainder = rem;

endmodule
`default_nettype wire

// ===== rtl/integer_to_radix_text_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_text_core
// Converts an integer word to ASCII text in a configurable radix, MSD first.
// ----------------------------------------------------------------------------
// Each digit costs one pass of the shared divider.
// s_tready stays low from the request until the last character is loaded,
// and stays low longer while m_tready holds the output.
// Reset (synchronous, rst high): sequencer idle, no output, radix 10, lower case.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_text_core_assert.svh"
module integer_to_radix_text_core
  import itrt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [VALUE_W-1:0]    s_tdata,   // [31:0] value_bits
  input  wire logic                  s_tuser,   // [0] is_signed
  // text channel
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,   // [6:0] text_char, [12:7] text_length
  output logic                       m_tlast,   // last
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [RADIX_W-1:0]    cfg_data
);

  localparam int MAG_W = ((DATA_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
  localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_SIGN  = 2'd2;
  localparam logic [1:0] S_DIGIT = 2'd3;

  logic [1:0]         state, state_next;
  logic [RADIX_W-1:0] radix;
  logic               letter_upper;
  logic               neg, neg_next;
  logic [LEN_W-1:0]   count, count_next;
  logic [LEN_W-1:0]   total, total_next;

  logic [CHAR_W-1:0]  out_char, char_next;
  logic [LEN_W-1:0]   out_len;
  logic               out_last_next;
  logic               out_load;
  logic               out_free;

  logic [EXT_W-1:0]      value_ext;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] mag_in;
  logic                  neg_in;
  logic                  accept;

  logic               div_start, div_busy, div_done;
  logic [MAG_W-1:0]   div_dividend, div_quot;
  logic [DIGIT_W-1:0] div_rem;
  logic [RADIX_W-1:0] base;

  logic                store_wr;
  logic [STORE_AW-1:0] store_rd_addr;
  logic [DIGIT_W-1:0]  store_rd_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign base      = eff_radix(radix);

  // only the low DATA_WIDTH bits of the word count
  assign value_ext = EXT_W'(s_tdata);
  assign word      = value_ext[DATA_WIDTH-1:0];
  assign neg_in    = s_tuser && word[DATA_WIDTH-1];
  assign mag_in    = neg_in ? (DATA_WIDTH'(0) - word) : word;

  assign div_start    = accept || (div_done && (div_quot != '0));
  assign div_dividend = accept ? MAG_W'(mag_in) : div_quot;

  itrt_div #(
    .MAG_W (MAG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign store_wr      = (state == S_DIV) && div_done && (count < LEN_W'(STORE_DEPTH));
  // read address tracks the updated count so data is ready in the following cycle
  assign store_rd_addr = STORE_AW'(count_next - LEN_W'(1));

  itrt_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (count[STORE_AW-1:0]),
    .wr_data (div_rem),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data)
  );

  always_comb begin
    state_next    = state;
    neg_next      = neg;
    count_next    = count;
    total_next    = total;
    out_load      = 1'b0;
    char_next     = CHAR_MINUS;
    out_last_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          neg_next   = neg_in;
          count_next = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (store_wr) begin
            count_next = count + LEN_W'(1);
          end
          if (div_quot == '0) begin
            total_next = count_next + LEN_W'(neg);
            state_next = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        if (!neg) begin
          state_next = S_DIGIT;
        end else if (out_free) begin
          out_load      = 1'b1;
          char_next     = CHAR_MINUS;
          out_last_next = (total == LEN_W'(1));
          state_next    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          char_next     = digit_char(store_rd_data, letter_upper);
          out_last_next = (count == LEN_W'(1));
          count_next    = count - LEN_W'(1);
          if (count == LEN_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      neg          <= 1'b0;
      count        <= '0;
      total        <= '0;
      m_tvalid     <= 1'b0;
      radix        <= RADIX_RESET;
      letter_upper <= 1'b0;
    end else begin
      state <= state_next;
      neg   <= neg_next;
      count <= count_next;
      total <= total_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIX: radix        <= cfg_data;
          REG_UPPER: letter_upper <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= char_next;
      out_len  <= total;
      m_tlast  <= out_last_next;
    end
  end

  assign m_tdata = {(OUT_DATA_W - LEN_W - CHAR_W)'(0), out_len, out_char};

  `ITRT_ASSERT_NXT(a_accept_starts_div, clk, rst, accept, div_busy && (state == S_DIV))
  `ITRT_ASSERT_IMP(a_rem_below_base, clk, rst, div_done, div_rem < base)
  `ITRT_ASSERT_IMP(a_digit_count_ok, clk, rst, state == S_DIGIT,
                   (count != '0) && (count <= LEN_W'(STORE_DEPTH)))
  `ITRT_ASSERT_NXT(a_last_ends_item, clk, rst, out_load && out_last_next,
                   state == S_IDLE)

endmodule
`default_nettype wire
